[src/cfvu_pkg.sv]
// ----------------------------------------------------------------------------
// cfvu_pkg: shared types and helpers for the contact friction velocity unit
// Widths of the fixed-point datapath, stage payload structs, divider step and
// output saturation.
// ----------------------------------------------------------------------------
package cfvu_pkg;

  // field widths
  localparam int VW   = 32;   // velocity Q16.16
  localparam int NW   = 16;   // normal Q1.14
  localparam int MW   = 32;   // inverse mass Q16.16
  localparam int FW   = 16;   // friction Q1.15
  localparam int IW   = 34;   // pair info
  // internal widths
  localparam int RLW  = 33;   // relative velocity
  localparam int PW   = 49;   // rel * n
  localparam int DW   = 50;   // dot sum
  localparam int SW   = 37;   // normal speed s
  localparam int QPW  = 53;   // n * s
  localparam int TW   = 38;   // tangential slip
  localparam int MRW  = 48;   // mass * friction
  localparam int MSW  = 33;   // mass sum
  localparam int NUMW = 59;   // divider numerator
  localparam int QB   = 28;   // quotient bits produced
  localparam int KW   = 27;   // useful quotient bits
  localparam int HW   = 19;   // slip split point
  localparam int LPW  = 46;   // low partial product
  localparam int HPW  = 47;   // high partial product
  localparam int ACW  = 66;   // final accumulator

  // pipeline shape
  localparam int SLIP_STAGES = 5;
  localparam int DIV_STAGES  = 14;
  localparam int STAGES      = SLIP_STAGES + DIV_STAGES + 2;

  localparam logic [FW-1:0] FRIC_ONE    = 16'd32768;
  localparam logic [7:0]    SLIP_SQ_MIN = 8'd43;
  localparam logic signed [TW-1:0] SLIP_BIG = 38'sd7;
  localparam logic signed [ACW-1:0] VEL_MAX = 66'sd2147483647;
  localparam logic signed [ACW-1:0] VEL_MIN = -66'sd2147483648;

  typedef logic [2:0][VW-1:0] vel3_t;

  typedef struct packed {
    vel3_t           va;
    vel3_t           vb;
    logic [2:0][NW-1:0] n;
    logic [MW-1:0]   ma;
    logic [MW-1:0]   mb;
    logic [IW-1:0]   info;
  } in_t;

  typedef struct packed {
    vel3_t va;
    vel3_t vb;
    logic  dyn_a;
    logic  dyn_b;
  } base_t;

  typedef struct packed {
    logic [MSW-1:0] rem;
    logic [QB-1:0]  lo;
    logic [QB-1:0]  q;
  } div_t;

  typedef struct packed {
    base_t              base;
    logic [2:0][TW-1:0] t;
    logic               go;
    div_t               da;
    div_t               db;
    logic [MSW-1:0]     den;
  } dpipe_t;

  typedef struct packed {
    vel3_t va;
    vel3_t vb;
    logic  applied;
  } out_t;

  // one restoring division step
  function automatic div_t div_step(div_t d, logic [MSW-1:0] den);
    logic [MSW:0]   sh;
    logic [MSW+1:0] diff;
    div_t           o;
    sh   = {d.rem, d.lo[QB-1]};
    diff = {1'b0, sh} - {2'b00, den};
    o.lo = {d.lo[QB-2:0], 1'b0};
    if (!diff[MSW+1]) begin
      o.rem = diff[MSW-1:0];
      o.q   = {d.q[QB-2:0], 1'b1};
    end else begin
      o.rem = sh[MSW-1:0];
      o.q   = {d.q[QB-2:0], 1'b0};
    end
    return o;
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic [VW-1:0] sat_vel(logic signed [ACW-1:0] x);
    logic [VW-1:0] r;
    if (x > VEL_MAX) r = VEL_MAX[VW-1:0];
    else if (x < VEL_MIN) r = VEL_MIN[VW-1:0];
    else r = x[VW-1:0];
    return r;
  endfunction

endpackage

[src/cfvu_slip.sv]
// ----------------------------------------------------------------------------
// cfvu_slip: tangential slip front end
// Five stages: relative velocity and normal products, normal speed, normal
// component, slip vector, slip test and divider setup.
// ----------------------------------------------------------------------------
module cfvu_slip import cfvu_pkg::*; (
  input  logic                   clk,
  input  logic [SLIP_STAGES-1:0] en,
  input  in_t                    d_i,
  output dpipe_t                 d_o
);

  // stage 1: relative velocity, dot terms, mass products
  base_t                 base1_r;
  logic signed [RLW-1:0] rel1_r [3];
  logic signed [NW-1:0]  n1_r   [3];
  logic signed [PW-1:0]  p1_r   [3];
  logic [MRW-1:0]        mra1_r, mrb1_r;
  logic [MSW-1:0]        msum1_r;

  logic                  dyn_a, dyn_b;
  logic [MW-1:0]         ma_m, mb_m;
  logic [FW-1:0]         fa, fb, fmax, fr;
  logic signed [RLW-1:0] rel_nxt [3];

  always_comb begin
    dyn_a = d_i.info[32];
    dyn_b = d_i.info[33];
    fa    = d_i.info[15:0];
    fb    = d_i.info[31:16];
    fmax  = (fa > fb) ? fa : fb;
    fr    = (fmax > FRIC_ONE) ? FRIC_ONE : fmax;
    ma_m  = dyn_a ? d_i.ma : '0;
    mb_m  = dyn_b ? d_i.mb : '0;
    for (int i = 0; i < 3; i++) begin
      rel_nxt[i] = (dyn_b ? {d_i.vb[i][VW-1], d_i.vb[i]} : '0)
                 - (dyn_a ? {d_i.va[i][VW-1], d_i.va[i]} : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      base1_r <= '{va: d_i.va, vb: d_i.vb, dyn_a: dyn_a, dyn_b: dyn_b};
      for (int i = 0; i < 3; i++) begin
        rel1_r[i] <= rel_nxt[i];
        n1_r[i]   <= $signed(d_i.n[i]);
        p1_r[i]   <= rel_nxt[i] * $signed(d_i.n[i]);
      end
      mra1_r  <= ma_m * fr;
      mrb1_r  <= mb_m * fr;
      msum1_r <= {1'b0, ma_m} + {1'b0, mb_m};
    end
  end

  // stage 2: normal speed s, divider numerators
  base_t                 base2_r;
  logic signed [RLW-1:0] rel2_r [3];
  logic signed [NW-1:0]  n2_r   [3];
  logic signed [SW-1:0]  s2_r;
  logic [NUMW-1:0]       numa2_r, numb2_r;
  logic [MSW-1:0]        msum2_r;

  logic signed [DW-1:0]  dot, dot_r;
  logic [NUMW-1:0]       half;

  always_comb begin
    dot = '0;
    for (int i = 0; i < 3; i++) dot = dot + {p1_r[i][PW-1], p1_r[i]};
    dot_r = (dot + DW'(8192)) >>> 14;
    half  = {{(NUMW-MSW+1){1'b0}}, msum1_r[MSW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      base2_r <= base1_r;
      rel2_r  <= rel1_r;
      n2_r    <= n1_r;
      s2_r    <= dot_r[SW-1:0];
      numa2_r <= {mra1_r, 11'b0} + half;
      numb2_r <= {mrb1_r, 11'b0} + half;
      msum2_r <= msum1_r;
    end
  end

  // stage 3: normal component products
  base_t                 base3_r;
  logic signed [RLW-1:0] rel3_r [3];
  logic signed [QPW-1:0] q3_r   [3];
  logic [NUMW-1:0]       numa3_r, numb3_r;
  logic [MSW-1:0]        msum3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      base3_r <= base2_r;
      rel3_r  <= rel2_r;
      for (int i = 0; i < 3; i++) q3_r[i] <= n2_r[i] * s2_r;
      numa3_r <= numa2_r;
      numb3_r <= numb2_r;
      msum3_r <= msum2_r;
    end
  end

  // stage 4: tangential slip
  base_t                 base4_r;
  logic signed [TW-1:0]  t4_r [3];
  logic [NUMW-1:0]       numa4_r, numb4_r;
  logic [MSW-1:0]        msum4_r;

  logic signed [QPW-1:0] qr  [3];
  logic signed [QPW-1:0] tt  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qr[i] = (q3_r[i] + QPW'(8192)) >>> 14;
      tt[i] = {{(QPW-RLW){rel3_r[i][RLW-1]}}, rel3_r[i]} - qr[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      base4_r <= base3_r;
      for (int i = 0; i < 3; i++) t4_r[i] <= tt[i][TW-1:0];
      numa4_r <= numa3_r;
      numb4_r <= numb3_r;
      msum4_r <= msum3_r;
    end
  end

  // stage 5: slip test, divider start
  logic              big;
  logic [7:0]        sq;
  logic signed [3:0] ts;
  logic signed [7:0] tsq;
  dpipe_t            d_nxt;

  always_comb begin
    big = 1'b0;
    sq  = '0;
    ts  = '0;
    tsq = '0;
    for (int i = 0; i < 3; i++) begin
      if (t4_r[i] >= SLIP_BIG || t4_r[i] <= -SLIP_BIG) begin
        big = 1'b1;
      end else begin
        ts  = t4_r[i][3:0];
        tsq = ts * ts;
        sq  = sq + tsq;
      end
    end
    d_nxt.base = base4_r;
    for (int i = 0; i < 3; i++) d_nxt.t[i] = t4_r[i];
    d_nxt.go   = (base4_r.dyn_a | base4_r.dyn_b) & (big | (sq >= SLIP_SQ_MIN))
               & (msum4_r != '0);
    d_nxt.da.rem = {{(MSW-NUMW+QB){1'b0}}, numa4_r[NUMW-1:QB]};
    d_nxt.da.lo  = numa4_r[QB-1:0];
    d_nxt.da.q   = '0;
    d_nxt.db.rem = {{(MSW-NUMW+QB){1'b0}}, numb4_r[NUMW-1:QB]};
    d_nxt.db.lo  = numb4_r[QB-1:0];
    d_nxt.db.q   = '0;
    d_nxt.den    = msum4_r;
  end

  always_ff @(posedge clk) begin
    if (en[4]) d_o <= d_nxt;
  end

endmodule

[src/cfvu_div_stage.sv]
// ----------------------------------------------------------------------------
// cfvu_div_stage: one divider stage
// Two restoring steps for both mass ratios, item payload carried along.
// ----------------------------------------------------------------------------
module cfvu_div_stage import cfvu_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  dpipe_t d_i,
  output dpipe_t d_o
);

  dpipe_t d_nxt;

  // two quotient bits per stage
  always_comb begin
    d_nxt    = d_i;
    d_nxt.da = div_step(div_step(d_i.da, d_i.den), d_i.den);
    d_nxt.db = div_step(div_step(d_i.db, d_i.den), d_i.den);
  end

  always_ff @(posedge clk) begin
    if (en) d_o <= d_nxt;
  end

endmodule

[src/cfvu_apply.sv]
// ----------------------------------------------------------------------------
// cfvu_apply: velocity correction back end
// Split slip-by-ratio products, then rounding, add and saturation into the
// output register.
// ----------------------------------------------------------------------------
module cfvu_apply import cfvu_pkg::*; (
  input  logic       clk,
  input  logic [1:0] en,
  input  dpipe_t     d_i,
  output out_t       d_o
);

  // stage 1: partial products
  base_t                 base1_r;
  logic                  go1_r;
  logic [LPW-1:0]        pla_r [3];
  logic [LPW-1:0]        plb_r [3];
  logic signed [HPW-1:0] pha_r [3];
  logic signed [HPW-1:0] phb_r [3];

  logic [KW-1:0] ka, kb;
  assign ka = d_i.da.q[KW-1:0];
  assign kb = d_i.db.q[KW-1:0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      base1_r <= d_i.base;
      go1_r   <= d_i.go;
      for (int i = 0; i < 3; i++) begin
        pla_r[i] <= d_i.t[i][HW-1:0] * ka;
        plb_r[i] <= d_i.t[i][HW-1:0] * kb;
        pha_r[i] <= $signed(d_i.t[i][TW-1:HW]) * $signed({1'b0, ka});
        phb_r[i] <= $signed(d_i.t[i][TW-1:HW]) * $signed({1'b0, kb});
      end
    end
  end

  // stage 2: round, apply, saturate
  logic signed [ACW-1:0] da [3];
  logic signed [ACW-1:0] db [3];
  logic signed [ACW-1:0] sa [3];
  logic signed [ACW-1:0] sb [3];
  out_t                  o_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      da[i] = $signed(({{(ACW-HPW){pha_r[i][HPW-1]}}, pha_r[i]} <<< HW)
              + {{(ACW-LPW){1'b0}}, pla_r[i]} + ACW'(33554432)) >>> 26;
      db[i] = $signed(({{(ACW-HPW){phb_r[i][HPW-1]}}, phb_r[i]} <<< HW)
              + {{(ACW-LPW){1'b0}}, plb_r[i]} + ACW'(33554432)) >>> 26;
      sa[i] = {{(ACW-VW){base1_r.va[i][VW-1]}}, base1_r.va[i]} + da[i];
      sb[i] = {{(ACW-VW){base1_r.vb[i][VW-1]}}, base1_r.vb[i]} - db[i];
      o_nxt.va[i] = (go1_r && base1_r.dyn_a) ? sat_vel(sa[i]) : base1_r.va[i];
      o_nxt.vb[i] = (go1_r && base1_r.dyn_b) ? sat_vel(sb[i]) : base1_r.vb[i];
    end
    o_nxt.applied = go1_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) d_o <= o_nxt;
  end

endmodule

[src/contact_friction_velocity_update_unit.sv]
// ----------------------------------------------------------------------------
// contact_friction_velocity_update_unit: tangential friction on one contact
//
//   channel | handshake             | payload
//   in      | in_valid / in_ready   | velocities, normal, inverse masses, info
//   out     | out_valid / out_ready | new velocities, applied
//
// One item per cycle sustained while out_ready stays high; 21 register stages.
// The 14-stage divider (two quotient bits per stage) sits between the
// 5-stage slip front end and the 2-stage correction back end.
// Each stage holds its item when the next one is full and stalled, so
// bubbles are squeezed out and nothing is lost or repeated.
// Synchronous active-low reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module contact_friction_velocity_update_unit import cfvu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [VW-1:0] in_vel_a_x,
  input  logic signed [VW-1:0] in_vel_a_y,
  input  logic signed [VW-1:0] in_vel_a_z,
  input  logic signed [VW-1:0] in_vel_b_x,
  input  logic signed [VW-1:0] in_vel_b_y,
  input  logic signed [VW-1:0] in_vel_b_z,
  input  logic signed [NW-1:0] in_normal_x,
  input  logic signed [NW-1:0] in_normal_y,
  input  logic signed [NW-1:0] in_normal_z,
  input  logic [MW-1:0]        in_inv_mass_a,
  input  logic [MW-1:0]        in_inv_mass_b,
  input  logic [IW-1:0]        in_pair_info,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [VW-1:0] out_new_vel_a_x,
  output logic signed [VW-1:0] out_new_vel_a_y,
  output logic signed [VW-1:0] out_new_vel_a_z,
  output logic signed [VW-1:0] out_new_vel_b_x,
  output logic signed [VW-1:0] out_new_vel_b_y,
  output logic signed [VW-1:0] out_new_vel_b_z,
  output logic                 out_applied
);

  // stage valid bits and load enables
  logic [STAGES-1:0] v_r, v_nxt;
  logic [STAGES:0]   rdy;

  always_comb begin
    rdy[STAGES] = out_ready;
    for (int i = STAGES - 1; i >= 0; i--) rdy[i] = !v_r[i] || rdy[i+1];
    for (int i = 0; i < STAGES; i++) begin
      if (rdy[i]) v_nxt[i] = (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i - 1];
      else        v_nxt[i] = v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[STAGES-1];

  // input item
  in_t item;
  always_comb begin
    item.va   = {in_vel_a_z, in_vel_a_y, in_vel_a_x};
    item.vb   = {in_vel_b_z, in_vel_b_y, in_vel_b_x};
    item.n    = {in_normal_z, in_normal_y, in_normal_x};
    item.ma   = in_inv_mass_a;
    item.mb   = in_inv_mass_b;
    item.info = in_pair_info;
  end

  // slip front end
  dpipe_t dp [DIV_STAGES+1];

  cfvu_slip u_slip (
    .clk (clk),
    .en  (rdy[SLIP_STAGES-1:0]),
    .d_i (item),
    .d_o (dp[0])
  );

  // divider chain
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    cfvu_div_stage u_div (
      .clk (clk),
      .en  (rdy[SLIP_STAGES+g]),
      .d_i (dp[g]),
      .d_o (dp[g+1])
    );
  end

  // correction back end
  out_t res;

  cfvu_apply u_apply (
    .clk (clk),
    .en  (rdy[STAGES-1:STAGES-2]),
    .d_i (dp[DIV_STAGES]),
    .d_o (res)
  );

  assign out_new_vel_a_x = res.va[0];
  assign out_new_vel_a_y = res.va[1];
  assign out_new_vel_a_z = res.va[2];
  assign out_new_vel_b_x = res.vb[0];
  assign out_new_vel_b_y = res.vb[1];
  assign out_new_vel_b_z = res.vb[2];
  assign out_applied     = res.applied;

  // checks
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output stage");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted item missing from first stage");

  a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[STAGES-2] && rdy[STAGES-1] |=> out_valid)
    else $error("item lost entering output stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[STAGES-2] && !rdy[STAGES-2] |=> v_r[STAGES-2])
    else $error("stalled stage dropped its item");

endmodule

[test/cfvu_checker.sv]
// ----------------------------------------------------------------------------
// cfvu_checker: result checker for the contact friction velocity unit
// Watches both channels, computes the expected velocities of every accepted
// contact item and compares each accepted result with the oldest expectation.
// ----------------------------------------------------------------------------
module cfvu_checker import cfvu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [VW-1:0] in_vel_a_x,
  input  logic signed [VW-1:0] in_vel_a_y,
  input  logic signed [VW-1:0] in_vel_a_z,
  input  logic signed [VW-1:0] in_vel_b_x,
  input  logic signed [VW-1:0] in_vel_b_y,
  input  logic signed [VW-1:0] in_vel_b_z,
  input  logic signed [NW-1:0] in_normal_x,
  input  logic signed [NW-1:0] in_normal_y,
  input  logic signed [NW-1:0] in_normal_z,
  input  logic [MW-1:0]        in_inv_mass_a,
  input  logic [MW-1:0]        in_inv_mass_b,
  input  logic [IW-1:0]        in_pair_info,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [VW-1:0] out_new_vel_a_x,
  input  logic signed [VW-1:0] out_new_vel_a_y,
  input  logic signed [VW-1:0] out_new_vel_a_z,
  input  logic signed [VW-1:0] out_new_vel_b_x,
  input  logic signed [VW-1:0] out_new_vel_b_y,
  input  logic signed [VW-1:0] out_new_vel_b_z,
  input  logic                 out_applied,
  output int                   fail_count,
  output int                   vel_pending
);

  out_t vel_expected[$];
  int   out_seen;

  // round to nearest, ties up, by 2^sh
  function automatic longint round_down_by(longint x, int sh);
    return (x + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic logic [VW-1:0] clamp_vel(longint x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[VW-1:0];
  endfunction

  // expected velocities after the tangential friction correction
  function automatic out_t friction_velocity(vel3_t va, vel3_t vb, logic [2:0][NW-1:0] n,
                                             logic [MW-1:0] ma_in, logic [MW-1:0] mb_in,
                                             logic [IW-1:0] info);
    out_t            res;
    longint          a[3], b[3], nn[3], rel[3], slip[3];
    longint          dot, spd, sq;
    longint unsigned ma, mb, msum, fa, fb, r, ka, kb;
    logic            dyn_a, dyn_b, go;
    res.va = va;
    res.vb = vb;
    res.applied = 1'b0;
    dyn_a = info[32];
    dyn_b = info[33];
    fa = info[15:0];
    fb = info[31:16];
    ma = ma_in;
    mb = mb_in;
    if (!dyn_a && !dyn_b) return res;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      a[i]   = longint'($signed(va[i]));
      b[i]   = longint'($signed(vb[i]));
      nn[i]  = longint'($signed(n[i]));
      rel[i] = (dyn_b ? b[i] : 0) - (dyn_a ? a[i] : 0);
      dot   += rel[i] * nn[i];
    end
    spd = round_down_by(dot, 14);
    // slip test: a big component passes at once, else squared length
    go = 1'b0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      slip[i] = rel[i] - round_down_by(nn[i] * spd, 14);
      if (slip[i] >= 7 || slip[i] <= -7) go = 1'b1;
      else sq += slip[i] * slip[i];
    end
    if (sq >= 43) go = 1'b1;
    if (!go) return res;
    if (!dyn_a) ma = 0;
    if (!dyn_b) mb = 0;
    msum = ma + mb;
    if (msum == 0) return res;
    r = (fa > fb) ? fa : fb;
    if (r > 32768) r = 32768;
    ka = (((ma * r) << 11) + (msum >> 1)) / msum;
    kb = (((mb * r) << 11) + (msum >> 1)) / msum;
    for (int i = 0; i < 3; i++) begin
      if (dyn_a) res.va[i] = clamp_vel(a[i] + round_down_by(slip[i] * longint'(ka), 26));
      if (dyn_b) res.vb[i] = clamp_vel(b[i] - round_down_by(slip[i] * longint'(kb), 26));
    end
    res.applied = 1'b1;
    return res;
  endfunction

  task automatic report(string what, logic [VW-1:0] got, logic [VW-1:0] want);
    $display("mismatch result %0d %s: got %h expected %h", out_seen, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial out_seen = 0;
  assign vel_pending = vel_expected.size();

  // predict on input accept, compare on output accept
  always @(posedge clk) begin
    out_t want;
    if (rst_n && in_valid && in_ready)
      vel_expected.push_back(friction_velocity(
        {in_vel_a_z, in_vel_a_y, in_vel_a_x}, {in_vel_b_z, in_vel_b_y, in_vel_b_x},
        {in_normal_z, in_normal_y, in_normal_x}, in_inv_mass_a, in_inv_mass_b,
        in_pair_info));
    if (rst_n && out_valid && out_ready) begin
      if (vel_expected.size() == 0) begin
        $display("unexpected result %0d", out_seen);
        fail_count++;
      end else begin
        want = vel_expected.pop_front();
        if (out_new_vel_a_x !== want.va[0]) report("new_vel_a_x", out_new_vel_a_x, want.va[0]);
        if (out_new_vel_a_y !== want.va[1]) report("new_vel_a_y", out_new_vel_a_y, want.va[1]);
        if (out_new_vel_a_z !== want.va[2]) report("new_vel_a_z", out_new_vel_a_z, want.va[2]);
        if (out_new_vel_b_x !== want.vb[0]) report("new_vel_b_x", out_new_vel_b_x, want.vb[0]);
        if (out_new_vel_b_y !== want.vb[1]) report("new_vel_b_y", out_new_vel_b_y, want.vb[1]);
        if (out_new_vel_b_z !== want.vb[2]) report("new_vel_b_z", out_new_vel_b_z, want.vb[2]);
        if (out_applied !== want.applied) report("applied", out_applied, want.applied);
      end
      out_seen++;
    end
  end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for contact_friction_velocity_update_unit
// Drives directed contacts (pass-through cases, slip threshold, friction
// clamp, saturation) and then random contacts in bursts, with a stalling
// receiver; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import cfvu_pkg::*;

  localparam int N_RANDOM    = 500;
  localparam int CYCLE_LIMIT = 200000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid, in_ready;
  logic signed [VW-1:0] in_vel_a_x, in_vel_a_y, in_vel_a_z;
  logic signed [VW-1:0] in_vel_b_x, in_vel_b_y, in_vel_b_z;
  logic signed [NW-1:0] in_normal_x, in_normal_y, in_normal_z;
  logic [MW-1:0]        in_inv_mass_a, in_inv_mass_b;
  logic [IW-1:0]        in_pair_info;
  logic                 out_valid, out_ready;
  logic signed [VW-1:0] out_new_vel_a_x, out_new_vel_a_y, out_new_vel_a_z;
  logic signed [VW-1:0] out_new_vel_b_x, out_new_vel_b_y, out_new_vel_b_z;
  logic                 out_applied;
  int                   fail_count, vel_pending;
  int                   cycle_count = 0;
  int                   burst_left = 0;

  always #10 clk = ~clk;

  contact_friction_velocity_update_unit DUT (.*);
  cfvu_checker u_checker (.*);

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: stall pattern steps through four modes as cycle_count advances
  always @(posedge clk) begin
    case ((cycle_count / 64) % 4)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 1);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((cycle_count % 7) < 5);
    endcase
  end

  // one contact item; gaps fall between random-length bursts
  task automatic send_contact(vel3_t va, vel3_t vb, logic [2:0][NW-1:0] n,
                              logic [MW-1:0] ma, logic [MW-1:0] mb, logic [IW-1:0] info);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    {in_vel_a_z, in_vel_a_y, in_vel_a_x} <= va;
    {in_vel_b_z, in_vel_b_y, in_vel_b_x} <= vb;
    {in_normal_z, in_normal_y, in_normal_x} <= n;
    in_inv_mass_a <= ma;
    in_inv_mass_b <= mb;
    in_pair_info  <= info;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [VW-1:0] rand_vel();
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2:       return $signed($urandom_range(0, 64)) - 32;
      default: return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000;
    endcase
  endfunction

  function automatic logic [2:0][NW-1:0] rand_normal();
    logic [2:0][NW-1:0] n;
    int ax;
    ax = $urandom_range(0, 2);
    n = '0;
    case ($urandom_range(0, 4))
      0: n[ax] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      1: begin
        n[ax] = 16'sd11585;
        n[(ax + 1) % 3] = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
      end
      2: n = {16'($urandom), 16'($urandom), 16'($urandom)};
      default: for (int i = 0; i < 3; i++)
        n[i] = 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
    return n;
  endfunction

  function automatic logic [MW-1:0] rand_mass();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return $urandom;
      default: return $urandom_range(1, 32'h40000);
    endcase
  endfunction

  function automatic logic [FW-1:0] rand_friction();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return FRIC_ONE;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [IW-1:0] rand_info();
    logic [1:0] dyn;
    dyn = $urandom_range(0, 5) == 0 ? 2'($urandom) : 2'b11;
    if ($urandom_range(0, 4) == 0) dyn[$urandom_range(0, 1)] = 1'b0;
    return {dyn, rand_friction(), rand_friction()};
  endfunction

  initial begin
    logic [2:0][NW-1:0] nz;
    nz = {16'sd16384, 16'sd0, 16'sd0};
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    out_ready     <= 1'b0;
    {in_vel_a_z, in_vel_a_y, in_vel_a_x} <= '0;
    {in_vel_b_z, in_vel_b_y, in_vel_b_x} <= '0;
    {in_normal_z, in_normal_y, in_normal_x} <= '0;
    in_inv_mass_a <= '0;
    in_inv_mass_b <= '0;
    in_pair_info  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pass-through cases, slip threshold, friction, saturation
    send_contact('0, '0, nz, 32'h10000, 32'h10000, {2'b11, 16'h4000, 16'h4000});
    send_contact({32'sd9, 32'sd7, 32'sd5}, '0, nz, 32'h10000, 32'h10000,
                 {2'b00, 16'h8000, 16'h8000});
    send_contact({32'sd900, -32'sd700, 32'sd5}, '0, nz, 32'h10000, 32'h20000,
                 {2'b01, 16'h8000, 16'h0});
    send_contact('0, {32'sd900, -32'sd700, 32'sd5}, nz, 32'h10000, 32'h20000,
                 {2'b10, 16'h0, 16'h6000});
    send_contact('0, {32'sd900, 32'sd700, 32'sd5}, nz, 32'h0, 32'h0,
                 {2'b11, 16'h8000, 16'h8000});
    send_contact('0, {32'sd900, 32'sd700, 32'sd5}, nz, 32'h0, 32'h10000,
                 {2'b01, 16'h8000, 16'h8000});
    send_contact('0, {32'sd0, 32'sd3, 32'sd3}, nz, 32'h10000, 32'h10000,
                 {2'b11, 16'h8000, 16'h8000});
    send_contact('0, {32'sd0, 32'sd4, 32'sd4}, nz, 32'h10000, 32'h10000,
                 {2'b11, 16'h8000, 16'h8000});
    send_contact('0, {32'sd0, 32'sd4, 32'sd5}, nz, 32'h10000, 32'h10000,
                 {2'b11, 16'h8000, 16'h8000});
    send_contact('0, {32'sd0, 32'sd0, 32'sd7}, nz, 32'h10000, 32'h10000,
                 {2'b11, 16'h8000, 16'h8000});
    send_contact('0, {32'sd0, 32'sd0, -32'sd6}, nz, 32'h10000, 32'h10000,
                 {2'b11, 16'h8000, 16'h8000});
    send_contact({32'sd100, 32'sd200, 32'sd300}, {32'sd5000, -32'sd4000, 32'sd0}, nz,
                 32'h10000, 32'h10000, {2'b11, 16'h0, 16'h0});
    send_contact({32'sd100, 32'sd200, 32'sd300}, {32'sd5000, -32'sd4000, 32'sd0}, nz,
                 32'h10000, 32'h30000, {2'b11, 16'hffff, 16'h1234});
    send_contact({32'sd100, 32'sd200, 32'sd300}, {32'sd5000, -32'sd4000, 32'sd0}, nz,
                 32'h10000, 32'h30000, {2'b11, 16'h8000, 16'h8001});
    send_contact({32'sd100, 32'sd200, 32'sd300}, {32'sd5000, -32'sd4000, 32'sd77},
                 {16'sh8000, 16'sh8000, 16'sh8000}, 32'h10000, 32'h10000,
                 {2'b11, 16'h8000, 16'h8000});
    send_contact({32'sd100, 32'sd200, 32'sd300}, {32'sd5000, -32'sd4000, 32'sd77},
                 {16'sd3000, 16'sd9000, -16'sd100}, 32'h10000, 32'h10000,
                 {2'b11, 16'h4000, 16'h2000});
    send_contact({3{32'h7fffffff}}, {3{32'h80000000}}, {16'sd0, 16'sd0, 16'sd16384},
                 32'hffffffff, 32'hffffffff, {2'b11, 16'h8000, 16'h8000});
    send_contact({3{32'h80000000}}, {3{32'h7fffffff}}, {16'sd0, 16'sd16384, 16'sd0},
                 32'hffffffff, 32'h1, {2'b11, 16'hffff, 16'hffff});
    send_contact({3{32'h7fffffff}}, {3{32'h80000000}}, {16'sd0, 16'sd16384, 16'sd0},
                 32'h1, 32'hffffffff, {2'b11, 16'hffff, 16'hffff});
    send_contact({3{32'hffffffff}}, {3{32'hffffffff}}, {3{16'hffff}},
                 32'hffffffff, 32'hffffffff, {34{1'b1}});

    // random contacts
    for (int k = 0; k < N_RANDOM; k++)
      send_contact({rand_vel(), rand_vel(), rand_vel()}, {rand_vel(), rand_vel(), rand_vel()},
                   rand_normal(), rand_mass(), rand_mass(), rand_info());
    in_valid <= 1'b0;

    // drain, then wait out any late results before the final check
    while (vel_pending != 0) @(posedge clk);
    repeat (3 * STAGES) @(posedge clk);
    if (fail_count == 0 && vel_pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
